>>> hw/rtl/opp_pkg.sv
// Shared types and constants of the onset peak picker.
package opp_pkg;

    localparam logic [1:0] OP_LOAD_FLUX   = 2'd0;
    localparam logic [1:0] OP_LOAD_SAMPLE = 2'd1;
    localparam logic [1:0] OP_STEP        = 2'd2;

    localparam logic [2:0] CFG_FRAME_COUNT      = 3'd0;
    localparam logic [2:0] CFG_SAMPLE_COUNT     = 3'd1;
    localparam logic [2:0] CFG_HOP_LENGTH       = 3'd2;
    localparam logic [2:0] CFG_WIN_RADIUS       = 3'd3;
    localparam logic [2:0] CFG_THRESHOLD_OFFSET = 3'd4;
    localparam logic [2:0] CFG_THRESHOLD_GAIN   = 3'd5;
    localparam logic [2:0] CFG_MIN_GAP_SAMPLES  = 3'd6;
    localparam logic [2:0] CFG_BACKTRACK_ENABLE = 3'd7;

    localparam int CFG_DATA_W = 24;

    localparam logic [12:0] RST_HOP_LENGTH     = 13'd512;
    localparam logic [6:0]  RST_WIN_RADIUS     = 7'd8;
    localparam logic [15:0] RST_THRESHOLD_GAIN = 16'd4096;

    typedef struct packed {
        logic [9:0]  frame_count;
        logic [16:0] sample_count;
        logic [12:0] hop_length;
        logic [6:0]  win_radius;
        logic [15:0] threshold_offset;
        logic [15:0] threshold_gain;
        logic [23:0] min_gap_samples;
        logic        backtrack_enable;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         operation;
        logic [15:0]        index;
        logic [15:0]        flux_value;
        logic signed [15:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic        onset_found;
        logic [15:0] onset_position;
        logic        done_res;
    } t_out_item;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_core_stat;

endpackage

>>> hw/rtl/onset_peak_picker_top.sv
// Onset peak picker: configuration registers, output register and core.
//
//  channel  direction  handshake                   payload
//  in       to block   i_in_valid / o_in_ready     i_in_data   (t_in_item)
//  out      from block o_out_valid / i_out_ready   o_out_data  (t_out_item)
//  cfg      to block   i_cfg_we                    i_cfg_index, i_cfg_wdata
//
// A step sweeps the median window (up to 2R+1 frames) through the flux store's
// single read port once per radix bit of the median, and for a backtracked
// onset it also walks the backtrack steps and searches a span of samples.
// Reset is synchronous, active low; the stores are not cleared.
// A result waits in the output register; the next item is taken meanwhile.
module onset_peak_picker_top
    import opp_pkg::*;
#(
    parameter int MAX_FRAMES  = 512,
    parameter int MAX_SAMPLES = 65536,
    parameter int MAX_RADIUS  = 64,
    parameter int HALF_WINDOW = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg       r_cfg;
    logic       r_ovalid;
    t_out_item  r_odata;
    t_core_stat stat;
    t_out_item  res;
    logic       slot_free, go;

    assign slot_free = !r_ovalid || i_out_ready;
    assign go        = i_in_valid && stat.idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_count      <= '0;
            r_cfg.sample_count     <= '0;
            r_cfg.hop_length       <= RST_HOP_LENGTH;
            r_cfg.win_radius       <= RST_WIN_RADIUS;
            r_cfg.threshold_offset <= '0;
            r_cfg.threshold_gain   <= RST_THRESHOLD_GAIN;
            r_cfg.min_gap_samples  <= '0;
            r_cfg.backtrack_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_COUNT:      r_cfg.frame_count      <= i_cfg_wdata[9:0];
                CFG_SAMPLE_COUNT:     r_cfg.sample_count     <= i_cfg_wdata[16:0];
                CFG_HOP_LENGTH:       r_cfg.hop_length       <= i_cfg_wdata[12:0];
                CFG_WIN_RADIUS:       r_cfg.win_radius       <= i_cfg_wdata[6:0];
                CFG_THRESHOLD_OFFSET: r_cfg.threshold_offset <= i_cfg_wdata[15:0];
                CFG_THRESHOLD_GAIN:   r_cfg.threshold_gain   <= i_cfg_wdata[15:0];
                CFG_MIN_GAP_SAMPLES:  r_cfg.min_gap_samples  <= i_cfg_wdata[23:0];
                CFG_BACKTRACK_ENABLE: r_cfg.backtrack_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (stat.res_valid) begin
            r_ovalid <= 1'b1;
            r_odata  <= res;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    opp_core #(
        .MAX_FRAMES  (MAX_FRAMES),
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_RADIUS  (MAX_RADIUS),
        .HALF_WINDOW (HALF_WINDOW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_go        (go),
        .i_item      (i_in_data),
        .i_slot_free (slot_free),
        .o_stat      (stat),
        .o_res       (res)
    );

    assign o_in_ready  = stat.idle;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.res_valid |-> (!r_ovalid || i_out_ready))
        else $error("result produced with output register occupied");

    a_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.onset_found) |-> (o_out_data.onset_position == 16'd0))
        else $error("position set without onset");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.operation == OP_STEP)) |=> !o_in_ready)
        else $error("ready after step transfer");

endmodule

>>> hw/rtl/opp_core.sv
// Stores, sweep sequencer and shared multiplier of the onset peak picker.
module opp_core
    import opp_pkg::*;
#(
    parameter int MAX_FRAMES  = 512,
    parameter int MAX_SAMPLES = 65536,
    parameter int MAX_RADIUS  = 64,
    parameter int HALF_WINDOW = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_go,
    input  t_in_item   i_item,
    input  logic       i_slot_free,
    output t_core_stat o_stat,
    output t_out_item  o_res
);

    localparam int FA = $clog2(MAX_FRAMES);
    localparam int SA = $clog2(MAX_SAMPLES);
    localparam int FN = FA + 1;
    localparam int SN = SA + 1;
    localparam int RN = $clog2(MAX_RADIUS + 1);
    localparam int LW = ((FN > RN) ? FN : RN) + 1;
    localparam int IW = (FN > SN) ? FN : SN;
    localparam int QW = (((FA + 13) > SN) ? (FA + 13) : SN) + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_SWEEP, S_NBR_END, S_RADIX_END, S_MUL_THR, S_MUL_POS,
        S_PICK, S_FOOT, S_FOOT_END, S_MUL_FROM, S_RANGE, S_MAX_END, S_FIND_END,
        S_SAT, S_GAP, S_EMIT
    } t_state;

    logic [15:0] r_flux_mem [MAX_FRAMES];
    logic [15:0] r_smp_mem  [MAX_SAMPLES];

    t_state      r_state, r_ret;
    logic [IW-1:0] r_ia, r_hi, r_pa, r_hidx;
    logic        r_pv;
    logic [15:0] r_fq, r_sq;
    logic [FN-1:0] r_cf, r_f, r_first, r_lastw, r_k, r_cnt, r_foot;
    logic        r_done, r_hit, r_have;
    logic [15:0] r_prev, r_cur, r_next, r_prefix, r_footval, r_fd, r_loud;
    logic [15:0] r_pos16, r_last_onset;
    logic [3:0]  r_bit;
    logic [31:0] r_prod;
    logic [32:0] r_thr;
    logic [QW-1:0] r_pos, r_from, r_slast;
    logic [RN-1:0] r_steps;
    t_out_item   r_res;

    logic [FN-1:0] fc;
    logic [SN-1:0] sc;
    logic [RN-1:0] rad;
    logic          flux_we, smp_we, is_step, step_out, step_done;
    logic [LW-1:0] win_hi;
    logic [FN-1:0] win_first, win_last, win_n;
    logic [15:0]   mul_a, mul_b;
    logic [31:0]   mul_p;
    logic [16:0]   mask17;
    logic          radix_hit, pick;
    logic [15:0]   mag;
    logic [19:0]   mag10;
    logic [QW-1:0] pos_raw, sc_m1, until_q;
    logic [24:0]   gap_end;

    always_comb begin
        fc  = (32'(i_cfg.frame_count) > 32'(MAX_FRAMES)) ? FN'(MAX_FRAMES)
                                                          : FN'(i_cfg.frame_count);
        sc  = (32'(i_cfg.sample_count) > 32'(MAX_SAMPLES)) ? SN'(MAX_SAMPLES)
                                                            : SN'(i_cfg.sample_count);
        rad = (32'(i_cfg.win_radius) > 32'(MAX_RADIUS)) ? RN'(MAX_RADIUS)
                                                         : RN'(i_cfg.win_radius);
        is_step   = i_go && (i_item.operation == OP_STEP);
        flux_we   = i_go && (i_item.operation == OP_LOAD_FLUX)
                    && (32'(i_item.index) < 32'(MAX_FRAMES));
        smp_we    = i_go && (i_item.operation == OP_LOAD_SAMPLE)
                    && (32'(i_item.index) < 32'(MAX_SAMPLES));
        step_out  = (fc < FN'(3)) || ((LW'(r_cf) + LW'(2)) > LW'(fc));
        step_done = (LW'(r_cf) + LW'(2)) == LW'(fc);
        // clipped median window around the frame about to be stepped
        win_hi    = LW'(r_cf) + LW'(rad) + LW'(1);
        win_last  = (win_hi > LW'(fc)) ? fc : FN'(win_hi);
        win_first = (LW'(r_cf) > LW'(rad)) ? FN'(LW'(r_cf) - LW'(rad)) : '0;
        win_n     = r_lastw - r_first;
        // radix select: entries that match the prefix above r_bit and hold 0 at r_bit
        mask17    = 17'h1FFFF << (5'(r_bit) + 5'd1);
        radix_hit = (((r_fq ^ r_prefix) & mask17[15:0]) == 16'd0) && !r_fq[r_bit];
        mag       = r_sq[15] ? (~r_sq + 16'd1) : r_sq;
        mag10     = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
        pick      = ({5'd0, r_cur, 12'd0} > r_thr) && (r_cur > r_prev) && (r_cur >= r_next);
        pos_raw   = QW'(r_prod);
        sc_m1     = QW'(sc) - QW'(1);
        until_q   = r_pos + QW'(HALF_WINDOW);
        gap_end   = 25'(r_last_onset) + 25'(i_cfg.min_gap_samples);
    end

    // one multiplier shared by threshold, frame position and foot position
    always_comb begin
        unique case (r_state)
            S_MUL_THR: begin
                mul_a = i_cfg.threshold_gain;
                mul_b = r_prefix;
            end
            S_MUL_POS: begin
                mul_a = 16'(r_f);
                mul_b = 16'(i_cfg.hop_length);
            end
            S_MUL_FROM: begin
                mul_a = 16'(r_foot);
                mul_b = 16'(i_cfg.hop_length);
            end
            default: begin
                mul_a = 16'd0;
                mul_b = 16'd0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (flux_we) begin
            r_flux_mem[FA'(i_item.index)] <= i_item.flux_value;
        end
        r_fq <= r_flux_mem[r_ia[FA-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            r_smp_mem[SA'(i_item.index)] <= i_item.sample_value;
        end
        r_sq <= r_smp_mem[r_ia[SA-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_pv         <= 1'b0;
            r_cf         <= FN'(1);
            r_last_onset <= 16'd0;
            r_have       <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (is_step) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (step_out) begin
                        r_res   <= '{onset_found: 1'b0, onset_position: 16'd0, done_res: 1'b1};
                        r_state <= S_EMIT;
                    end else begin
                        r_f    <= r_cf;
                        r_done <= step_done;
                        r_cf   <= r_cf + FN'(1);
                        if ((i_cfg.hop_length == 13'd0) || (sc == '0)) begin
                            r_res   <= '{onset_found: 1'b0, onset_position: 16'd0,
                                         done_res: step_done};
                            r_state <= S_EMIT;
                        end else begin
                            r_first <= win_first;
                            r_lastw <= win_last;
                            r_ia    <= IW'(r_cf) - IW'(1);
                            r_hi    <= IW'(r_cf) + IW'(2);
                            r_ret   <= S_NBR_END;
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    if (r_ia < r_hi) begin
                        r_ia <= r_ia + IW'(1);
                        r_pa <= r_ia;
                        r_pv <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        unique case (r_ret)
                            S_NBR_END: begin
                                if (r_pa == IW'(r_f) - IW'(1)) begin
                                    r_prev <= r_fq;
                                end else if (r_pa == IW'(r_f)) begin
                                    r_cur <= r_fq;
                                end else begin
                                    r_next <= r_fq;
                                end
                            end
                            S_RADIX_END: begin
                                if (radix_hit) begin
                                    r_cnt <= r_cnt + FN'(1);
                                end
                            end
                            S_FOOT_END: r_fd <= r_fq;
                            S_MAX_END: begin
                                if (mag > r_loud) begin
                                    r_loud <= mag;
                                end
                            end
                            S_FIND_END: begin
                                if (!r_hit && (mag10 >= {4'd0, r_loud})) begin
                                    r_hit  <= 1'b1;
                                    r_hidx <= r_pa;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if ((r_ia >= r_hi) && !r_pv) begin
                        r_state <= r_ret;
                    end
                end
                S_NBR_END: begin
                    r_k      <= win_n >> 1;
                    r_cnt    <= '0;
                    r_bit    <= 4'd15;
                    r_prefix <= 16'd0;
                    r_ia     <= IW'(r_first);
                    r_hi     <= IW'(r_lastw);
                    r_ret    <= S_RADIX_END;
                    r_state  <= S_SWEEP;
                end
                S_RADIX_END: begin
                    if (r_k >= r_cnt) begin
                        r_k             <= r_k - r_cnt;
                        r_prefix[r_bit] <= 1'b1;
                    end
                    if (r_bit == 4'd0) begin
                        r_state <= S_MUL_THR;
                    end else begin
                        r_bit   <= r_bit - 4'd1;
                        r_cnt   <= '0;
                        r_ia    <= IW'(r_first);
                        r_hi    <= IW'(r_lastw);
                        r_state <= S_SWEEP;
                    end
                end
                S_MUL_THR: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL_POS;
                end
                S_MUL_POS: begin
                    // threshold in Q21.12: offset << 12 plus gain * median
                    r_thr   <= {5'd0, i_cfg.threshold_offset, 12'd0} + {1'b0, r_prod};
                    r_prod  <= mul_p;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (!pick) begin
                        r_res   <= '{onset_found: 1'b0, onset_position: 16'd0,
                                     done_res: r_done};
                        r_state <= S_EMIT;
                    end else begin
                        r_pos <= (pos_raw > sc_m1) ? sc_m1 : pos_raw;
                        if (i_cfg.backtrack_enable) begin
                            r_foot    <= r_f;
                            r_steps   <= '0;
                            r_footval <= r_cur;
                            r_state   <= S_FOOT;
                        end else begin
                            r_state <= S_SAT;
                        end
                    end
                end
                S_FOOT: begin
                    if ((r_foot != '0) && (r_steps < rad)) begin
                        r_ia    <= IW'(r_foot) - IW'(1);
                        r_hi    <= IW'(r_foot);
                        r_ret   <= S_FOOT_END;
                        r_state <= S_SWEEP;
                    end else begin
                        r_state <= S_MUL_FROM;
                    end
                end
                S_FOOT_END: begin
                    if (r_fd < r_footval) begin
                        r_foot    <= r_foot - FN'(1);
                        r_steps   <= r_steps + RN'(1);
                        r_footval <= r_fd;
                        r_state   <= S_FOOT;
                    end else begin
                        r_state <= S_MUL_FROM;
                    end
                end
                S_MUL_FROM: begin
                    r_prod  <= mul_p;
                    r_slast <= (until_q > QW'(sc)) ? QW'(sc) : until_q;
                    r_state <= S_RANGE;
                end
                S_RANGE: begin
                    r_from <= pos_raw;
                    if (r_slast <= pos_raw) begin
                        r_pos   <= pos_raw;
                        r_state <= S_SAT;
                    end else begin
                        r_loud  <= 16'd0;
                        r_ia    <= IW'(pos_raw);
                        r_hi    <= IW'(r_slast);
                        r_ret   <= S_MAX_END;
                        r_state <= S_SWEEP;
                    end
                end
                S_MAX_END: begin
                    if (r_loud == 16'd0) begin
                        r_pos   <= r_from;
                        r_state <= S_SAT;
                    end else begin
                        r_hit   <= 1'b0;
                        r_ia    <= IW'(r_from);
                        r_hi    <= IW'(r_slast);
                        r_ret   <= S_FIND_END;
                        r_state <= S_SWEEP;
                    end
                end
                S_FIND_END: begin
                    r_pos   <= r_hit ? QW'(r_hidx) : r_from;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_pos16 <= (r_pos > QW'(16'hFFFF)) ? 16'hFFFF : r_pos[15:0];
                    r_state <= S_GAP;
                end
                S_GAP: begin
                    if (r_have && (25'(r_pos16) < gap_end)) begin
                        r_res <= '{onset_found: 1'b0, onset_position: 16'd0,
                                   done_res: r_done};
                    end else begin
                        r_res        <= '{onset_found: 1'b1, onset_position: r_pos16,
                                          done_res: r_done};
                        r_last_onset <= r_pos16;
                        r_have       <= 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_EMIT) && i_slot_free;
    assign o_res            = r_res;

endmodule

>>> tb/sv/testbench.sv
// Testbench for the onset peak picker: directed and random scans checked against a predictor.
`timescale 1ns / 1ps
module testbench;
    import opp_pkg::*;

    localparam int N_FRAMES   = 512;
    localparam int N_SAMPLES  = 65536;
    localparam int RADIUS_CAP = 64;
    localparam int HALF_WIN   = 512;
    localparam int ITEM_GOAL  = 290;
    localparam int CYCLE_CAP  = 3000000;
    localparam int SETTLE     = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state
    logic [15:0]     flux_mem [N_FRAMES];
    shortint         smp_mem [N_SAMPLES];
    bit              flux_ok [N_FRAMES];
    bit              smp_ok [N_SAMPLES];
    int unsigned     cur_frame = 1;
    longint unsigned last_onset = 0;
    bit              have_onset = 1'b0;
    t_cfg            cfg = '{frame_count: '0, sample_count: '0, hop_length: RST_HOP_LENGTH,
                             win_radius: RST_WIN_RADIUS, threshold_offset: '0,
                             threshold_gain: RST_THRESHOLD_GAIN, min_gap_samples: '0,
                             backtrack_enable: 1'b1};

    t_out_item onset_q[$];
    int        err_cnt = 0;
    int        items_sent = 0;
    int        cycles = 0;
    bit        calm = 1'b0;

    onset_peak_picker_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (onset_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = onset_q.pop_front();
                if (out_data.onset_found !== want.onset_found)
                    report_mismatch($sformatf("onset_found %0b, want %0b",
                                              out_data.onset_found, want.onset_found));
                if (out_data.onset_position !== want.onset_position)
                    report_mismatch($sformatf("onset_position %0d, want %0d",
                                              out_data.onset_position, want.onset_position));
                if (out_data.done_res !== want.done_res)
                    report_mismatch($sformatf("done_res %0b, want %0b",
                                              out_data.done_res, want.done_res));
            end
        end
    end

    // first sample in [from, stop_at) whose 10*|x| reaches the loudest |x| there
    function automatic longint unsigned attack_point(longint unsigned from,
                                                     longint unsigned stop_at,
                                                     int unsigned scnt);
        longint unsigned stop;
        int unsigned     loud;
        int              x;
        stop = (stop_at < scnt) ? stop_at : scnt;
        loud = 0;
        if (stop <= from) return from;
        for (longint unsigned i = from; i < stop; i++) begin
            x = smp_mem[i];
            if (x < 0) x = -x;
            if (x > loud) loud = x;
        end
        if (loud == 0) return from;
        for (longint unsigned i = from; i < stop; i++) begin
            x = smp_mem[i];
            if (x < 0) x = -x;
            if (10 * x >= loud) return i;
        end
        return from;
    endfunction

    task automatic model_item(input t_in_item it);
        int unsigned     fcnt, scnt, rad, f, foot, steps, first, stop;
        longint unsigned pos, v, thr, med;
        logic [15:0]     win[$];
        t_out_item       res;
        case (it.operation)
            OP_LOAD_FLUX: begin
                if (it.index < N_FRAMES) begin
                    flux_mem[it.index] = it.flux_value;
                    flux_ok[it.index] = 1'b1;
                end
            end
            OP_LOAD_SAMPLE: begin
                smp_mem[it.index] = it.sample_value;
                smp_ok[it.index] = 1'b1;
            end
            OP_STEP: begin
                fcnt = (cfg.frame_count > N_FRAMES) ? N_FRAMES : cfg.frame_count;
                scnt = (cfg.sample_count > N_SAMPLES) ? N_SAMPLES : cfg.sample_count;
                rad  = (cfg.win_radius > RADIUS_CAP) ? RADIUS_CAP : cfg.win_radius;
                res = '0;
                res.done_res = 1'b1;
                if (fcnt >= 3 && cur_frame <= fcnt - 2) begin
                    f = cur_frame;
                    res.done_res = (f == fcnt - 2);
                    cur_frame = f + 1;
                    if (cfg.hop_length != 0 && scnt != 0) begin
                        first = (f > rad) ? f - rad : 0;
                        stop = f + rad + 1;
                        if (stop > fcnt) stop = fcnt;
                        for (int unsigned i = first; i < stop; i++) win = {win, flux_mem[i]};
                        win.sort();
                        med = win[win.size() / 2];
                        v = flux_mem[f];
                        thr = (longint'(cfg.threshold_offset) << 12)
                              + longint'(cfg.threshold_gain) * med;
                        if ((v << 12) > thr && v > flux_mem[f-1] && v >= flux_mem[f+1]) begin
                            pos = longint'(f) * cfg.hop_length;
                            if (pos > scnt - 1) pos = scnt - 1;
                            if (cfg.backtrack_enable) begin
                                foot = f;
                                steps = 0;
                                while (foot > 0 && steps < rad
                                       && flux_mem[foot-1] < flux_mem[foot]) begin
                                    foot--;
                                    steps++;
                                end
                                pos = attack_point(longint'(foot) * cfg.hop_length,
                                                   pos + HALF_WIN, scnt);
                            end
                            if (pos > 65535) pos = 65535;
                            if (!(have_onset && pos < last_onset + cfg.min_gap_samples)) begin
                                res.onset_found = 1'b1;
                                res.onset_position = pos[15:0];
                                last_onset = pos;
                                have_onset = 1'b1;
                            end
                        end
                    end
                end
                onset_q = {onset_q, res};
            end
            default: ;
        endcase
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input t_in_item it);
        int gap;
        gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        model_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (onset_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // drives one register write, then drops the write enable before returning
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_FRAME_COUNT:      cfg.frame_count      = val[9:0];
            CFG_SAMPLE_COUNT:     cfg.sample_count     = val[16:0];
            CFG_HOP_LENGTH:       cfg.hop_length       = val[12:0];
            CFG_WIN_RADIUS:       cfg.win_radius       = val[6:0];
            CFG_THRESHOLD_OFFSET: cfg.threshold_offset = val[15:0];
            CFG_THRESHOLD_GAIN:   cfg.threshold_gain   = val[15:0];
            CFG_MIN_GAP_SAMPLES:  cfg.min_gap_samples  = val[23:0];
            CFG_BACKTRACK_ENABLE: cfg.backtrack_enable = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic [1:0] op, input logic [15:0] idx,
                                           input logic [15:0] flux, input logic [15:0] smp);
        t_in_item it;
        it.operation    = op;
        it.index        = idx;
        it.flux_value   = flux;
        it.sample_value = smp;
        return it;
    endfunction

    // load whatever the next step may read and has never been written
    task automatic fill_before_step();
        int unsigned fcnt, scnt, rad, lo, hi;
        fcnt = (cfg.frame_count > N_FRAMES) ? N_FRAMES : cfg.frame_count;
        scnt = (cfg.sample_count > N_SAMPLES) ? N_SAMPLES : cfg.sample_count;
        rad  = (cfg.win_radius > RADIUS_CAP) ? RADIUS_CAP : cfg.win_radius;
        if (fcnt < 3 || cur_frame > fcnt - 2 || cfg.hop_length == 0 || scnt == 0) return;
        lo = (cur_frame > rad + 1) ? cur_frame - rad - 1 : 0;
        hi = (cur_frame + rad + 1 < fcnt) ? cur_frame + rad + 1 : fcnt - 1;
        for (int unsigned i = lo; i <= hi; i++)
            if (!flux_ok[i])
                send_item(make_item(OP_LOAD_FLUX, i[15:0],
                                    ($urandom_range(3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(12000)),
                                    16'($urandom)));
        for (int unsigned i = 0; i < scnt; i++)
            if (!smp_ok[i])
                send_item(make_item(OP_LOAD_SAMPLE, i[15:0], 16'($urandom),
                                    ($urandom_range(1) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(600))));
    endtask

    task automatic step_frame();
        fill_before_step();
        send_item(make_item(OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    // fresh out of reset: too few frames, ignored codes and addresses, field extremes
    task automatic test_reset_state();
        step_frame();
        send_item(make_item(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_item(OP_LOAD_FLUX, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_item(make_item(OP_LOAD_FLUX, 16'd512, 16'h1234, 16'h0000));
        send_item(make_item(OP_LOAD_SAMPLE, 16'hFFFF, 16'h0000, 16'h8000));
        send_item(make_item(OP_LOAD_SAMPLE, 16'hFFFE, 16'hFFFF, 16'h7FFF));
        step_frame();
        wait_drained();
    endtask

    // short scan with known peaks, then steps past the end
    task automatic test_short_scan();
        logic [15:0] shape [8] = '{16'd0, 16'd200, 16'd5000, 16'd3000,
                                   16'd100, 16'hFFFF, 16'hFFFF, 16'd10};
        write_reg(CFG_FRAME_COUNT, 24'd8);
        write_reg(CFG_SAMPLE_COUNT, 24'd12);
        write_reg(CFG_HOP_LENGTH, 24'd2);
        write_reg(CFG_WIN_RADIUS, 24'd1);
        for (int i = 0; i < 8; i++)
            send_item(make_item(OP_LOAD_FLUX, i[15:0], shape[i], 16'h0));
        for (int i = 0; i < 12; i++)
            send_item(make_item(OP_LOAD_SAMPLE, i[15:0], 16'h0,
                                (i == 9) ? 16'h8000 : (i == 4) ? 16'h7FFF : 16'(i * 300)));
        repeat (8) step_frame();
        wait_drained();
    endtask

    // register extremes; a zero hop or no samples keeps the stores untouched
    task automatic test_register_extremes();
        write_reg(CFG_FRAME_COUNT, 24'h3FF);
        write_reg(CFG_SAMPLE_COUNT, 24'h1FFFF);
        write_reg(CFG_HOP_LENGTH, 24'd0);
        write_reg(CFG_WIN_RADIUS, 24'h7F);
        write_reg(CFG_THRESHOLD_OFFSET, 24'hFFFF);
        write_reg(CFG_THRESHOLD_GAIN, 24'hFFFF);
        write_reg(CFG_MIN_GAP_SAMPLES, 24'hFFFFFF);
        write_reg(CFG_BACKTRACK_ENABLE, 24'd0);
        repeat (3) step_frame();
        wait_drained();
        write_reg(CFG_SAMPLE_COUNT, 24'd0);
        write_reg(CFG_HOP_LENGTH, 24'h1FFF);
        repeat (2) step_frame();
        wait_drained();
    endtask

    task automatic test_random_scans();
        int unsigned fcnt;
        int          phase;
        phase = 0;
        while (items_sent < ITEM_GOAL && cur_frame < N_FRAMES - 30) begin
            calm = (phase == 2);
            fcnt = cur_frame + $urandom_range(6, 20);
            write_reg(CFG_FRAME_COUNT, 24'(fcnt));
            write_reg(CFG_SAMPLE_COUNT, 24'((phase == 1) ? 1 : $urandom_range(2, 80)));
            write_reg(CFG_HOP_LENGTH, 24'((phase == 3) ? 4096 : $urandom_range(1, 6)));
            write_reg(CFG_WIN_RADIUS, 24'((phase == 4) ? 64 : $urandom_range(0, 5)));
            write_reg(CFG_THRESHOLD_OFFSET, 24'($urandom_range(0, 1500)));
            write_reg(CFG_THRESHOLD_GAIN, 24'($urandom_range(1024, 6000)));
            write_reg(CFG_MIN_GAP_SAMPLES,
                      24'(($urandom_range(2) == 0) ? 0 : $urandom_range(1, 30)));
            write_reg(CFG_BACKTRACK_ENABLE, 24'($urandom_range(1)));
            while (cur_frame <= fcnt - 2) begin
                case ($urandom_range(9))
                    0: send_item(make_item(OP_LOAD_FLUX, 16'($urandom_range(cur_frame + 1,
                                           fcnt - 1)), 16'($urandom), 16'($urandom)));
                    1: send_item(make_item(OP_LOAD_SAMPLE, 16'($urandom), 16'($urandom),
                                           16'($urandom)));
                    2: send_item(make_item($urandom_range(1) ? 2'd3 : OP_LOAD_FLUX,
                                           16'($urandom_range(512, 65535)), 16'($urandom),
                                           16'($urandom)));
                    3: if (phase == 5) wait_drained();
                    default: ;
                endcase
                step_frame();
            end
            if ($urandom_range(1)) step_frame();
            wait_drained();
            phase++;
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_state();
        test_short_scan();
        test_register_extremes();
        test_random_scans();
        wait_drained();
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
